// ----- design/fsd_pkg.sv -----
// Shared types and constants for the Floyd-Steinberg RGB dither block.
// No dependencies; every other design file but fsd_ram refers to it by scoped names.
`timescale 1ns / 1ps

package fsd_pkg;

  localparam int LW_W  = 12;  // line_width register width
  localparam int FH_W  = 13;  // frame_height register width
  localparam int ROW_W = 12;  // row counter width
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 13;

  localparam int MAX_FRAME_HEIGHT = 4096;
  localparam int LINE_WIDTH_RESET = 640;
  localparam int FRAME_HEIGHT_RESET = 480;

  localparam int ON_THRESHOLD = 128;
  localparam int FULL_SCALE   = 255;

  // error shares, all over 16
  localparam int SHARE_RIGHT       = 7;
  localparam int SHARE_BELOW_LEFT  = 3;
  localparam int SHARE_BELOW       = 5;
  localparam int SHARE_BELOW_RIGHT = 1;
  localparam int SHARE_SHIFT       = 4;

  localparam int NUM_CHANNELS   = 3;
  localparam int OUT_FIFO_DEPTH = 4;
  localparam int OUT_PTR_W      = 2;
  localparam int OUT_CNT_W      = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LINE_WIDTH   = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pix_t;

  typedef struct packed {
    logic red_on;
    logic green_on;
    logic blue_on;
    logic end_of_row;
    logic end_of_image;
  } dith_t;

endpackage

// ----- design/fsd_ram.sv -----
// Generic single-write, single-read RAM with registered read data (read-first).
// No dependencies.
`timescale 1ns / 1ps

module fsd_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/fsd_lane.sv -----
// One color channel of the dither core: threshold, error and the four shares.
// Uses fsd_pkg constants.
`timescale 1ns / 1ps

module fsd_lane #(
  parameter int EB = 10
) (
  input  logic [7:0]           sample,
  input  logic signed [EB-1:0] carry,
  input  logic signed [EB-1:0] stored,
  input  logic signed [EB-1:0] pend_left,
  input  logic signed [EB-1:0] pend_mid,
  output logic                 on,
  output logic signed [EB-1:0] share_right,
  output logic signed [EB-1:0] sum_left,
  output logic signed [EB-1:0] sum_mid,
  output logic signed [EB-1:0] share_lr
);

  localparam int W = EB + 3;
  localparam logic signed [W-1:0] HI = W'((1 << (EB - 1)) - 1);
  localparam logic signed [W-1:0] LO = W'(-(1 << (EB - 1)));
  localparam logic signed [W-1:0] THRESH = W'(fsd_pkg::ON_THRESHOLD);
  localparam logic signed [W-1:0] FULL = W'(fsd_pkg::FULL_SCALE);
  localparam logic signed [W-1:0] RND = W'((1 << fsd_pkg::SHARE_SHIFT) - 1);

  function automatic logic signed [EB-1:0] sat(input logic signed [W-1:0] x);
    if (x > HI) return HI[EB-1:0];
    if (x < LO) return LO[EB-1:0];
    return x[EB-1:0];
  endfunction

  function automatic logic signed [W-1:0] ext(input logic signed [EB-1:0] x);
    return {{(W-EB){x[EB-1]}}, x};
  endfunction

  // divide by 16 truncating toward zero
  function automatic logic signed [EB-1:0] div16(input logic signed [W-1:0] p);
    logic signed [W-1:0] t;
    t = p + (p[W-1] ? RND : '0);
    t = t >>> fsd_pkg::SHARE_SHIFT;
    return t[EB-1:0];
  endfunction

  logic signed [W-1:0] v;
  logic signed [W-1:0] e_x;
  logic signed [EB-1:0] e;

  always_comb begin
    v = $signed({{(W-8){1'b0}}, sample}) + ext(carry) + ext(stored);
    on = (v >= THRESH);
    e = sat(v - (on ? FULL : '0));
    e_x = ext(e);
    share_right = div16(e_x * W'(fsd_pkg::SHARE_RIGHT));
    share_lr = div16(e_x * W'(fsd_pkg::SHARE_BELOW_RIGHT));
    sum_left = sat(ext(pend_left) + ext(div16(e_x * W'(fsd_pkg::SHARE_BELOW_LEFT))));
    sum_mid = sat(ext(pend_mid) + ext(div16(e_x * W'(fsd_pkg::SHARE_BELOW))));
  end

endmodule

// ----- design/fsd_out_fifo.sv -----
// Small result FIFO that decouples the dither core from the output stall.
// Uses fsd_pkg for the result type and depth.
`timescale 1ns / 1ps

module fsd_out_fifo (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  fsd_pkg::dith_t                  push_data,
  input  logic                            pop,
  output fsd_pkg::dith_t                  head,
  output logic [fsd_pkg::OUT_CNT_W-1:0]   count
);

  fsd_pkg::dith_t entries [fsd_pkg::OUT_FIFO_DEPTH];
  logic [fsd_pkg::OUT_PTR_W-1:0] wr_ptr;
  logic [fsd_pkg::OUT_PTR_W-1:0] rd_ptr;
  logic do_pop;

  assign do_pop = pop && (count != '0);
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + {{(fsd_pkg::OUT_CNT_W-1){1'b0}}, push}
                     - {{(fsd_pkg::OUT_CNT_W-1){1'b0}}, do_pop};
    end
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- design/floyd_steinberg_dither_rgb.sv -----
// Floyd-Steinberg RGB dither. A pixel goes via the stage 1 registers into the output FIFO.
// Throughput: 1 pixel per cycle unless stalled; the right-neighbor carry loop closes in stage 1.
// Reset (rst, synchronous): clears counters, carries, pending sums and the output FIFO;
// line_width and frame_height return to 640 and 480. The line store is not cleared:
// the first row of a frame ignores it.
// Depends on fsd_pkg, fsd_ram, fsd_lane, fsd_out_fifo.
`timescale 1ns / 1ps

module floyd_steinberg_dither_rgb #(
  parameter int MAX_LINE_WIDTH = 2048,
  parameter int ERROR_BITS = 10
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             pix_valid,
  output logic                             pix_stall,
  input  fsd_pkg::pix_t                    pix,
  output logic                             dith_valid,
  input  logic                             dith_stall,
  output fsd_pkg::dith_t                   dith,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fsd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [fsd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int EB = ERROR_BITS;
  localparam int NC = fsd_pkg::NUM_CHANNELS;
  localparam int AW = $clog2(MAX_LINE_WIDTH);
  localparam int CMP_W = (AW + 1 > fsd_pkg::LW_W) ? AW + 1 : fsd_pkg::LW_W;
  localparam int FH_W = fsd_pkg::FH_W;
  localparam int ROW_W = fsd_pkg::ROW_W;
  localparam int MW = NC * EB;

  // configuration
  logic [fsd_pkg::LW_W-1:0] line_width;
  logic [FH_W-1:0]          frame_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= fsd_pkg::LW_W'(fsd_pkg::LINE_WIDTH_RESET);
      frame_height <= FH_W'(fsd_pkg::FRAME_HEIGHT_RESET);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fsd_pkg::REG_LINE_WIDTH:   line_width <= cfg_data[fsd_pkg::LW_W-1:0];
        fsd_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data[FH_W-1:0];
        default: ;
      endcase
    end
  end

  // stage 0: position counters and line-store read
  logic [AW-1:0]    col;
  logic [ROW_W-1:0] row;
  logic [CMP_W-1:0] col1;
  logic [FH_W-1:0]  row1;
  logic eor, last_row, eoi, accept;

  assign accept = pix_valid && !pix_stall;
  assign col1 = CMP_W'(col) + 1'b1;
  assign row1 = FH_W'(row) + 1'b1;
  // a zero width acts as one; widths above the store act as its depth
  assign eor = (col1 >= CMP_W'(line_width)) || (col1 >= CMP_W'(MAX_LINE_WIDTH));
  assign last_row = (row1 >= frame_height) || (row1 >= FH_W'(fsd_pkg::MAX_FRAME_HEIGHT));
  assign eoi = eor && last_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (eor) begin
        col <= '0;
        row <= eoi ? '0 : row1[ROW_W-1:0];
      end else begin
        col <= col1[AW-1:0];
      end
    end
  end

  // line store write port
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [MW-1:0] wr_data;
  logic [MW-1:0] rd_data;

  fsd_ram #(
    .WIDTH(MW),
    .DEPTH(MAX_LINE_WIDTH)
  ) u_line (
    .clk(clk),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en(accept),
    .rd_addr(col),
    .rd_data(rd_data)
  );

  // stage 1 registers
  logic          s1_valid;
  fsd_pkg::pix_t s1_pix;
  logic [AW-1:0] s1_col;
  logic          s1_eor, s1_eoi, s1_below, s1_first;
  logic          s1_fwd_hit;
  logic [MW-1:0] s1_fwd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1_pix <= pix;
      s1_col <= col;
      s1_eor <= eor;
      s1_eoi <= eoi;
      s1_below <= !last_row;
      s1_first <= (row == '0);
      // a same-cycle write to the address being read is forwarded
      s1_fwd_hit <= wr_en && (wr_addr == col);
      s1_fwd_data <= wr_data;
    end
  end

  // lanes
  logic [MW-1:0] stored_raw;
  logic [7:0] samples [NC];
  logic signed [EB-1:0] right_carry [NC];
  logic signed [EB-1:0] pend_left [NC];
  logic signed [EB-1:0] pend_mid [NC];
  logic signed [EB-1:0] stored [NC];
  logic signed [EB-1:0] share_right [NC];
  logic signed [EB-1:0] sum_left [NC];
  logic signed [EB-1:0] sum_mid [NC];
  logic signed [EB-1:0] share_lr [NC];
  logic [NC-1:0] on;
  logic [MW-1:0] left_word, mid_word;

  assign stored_raw = s1_fwd_hit ? s1_fwd_data : rd_data;
  assign samples[0] = s1_pix.red_in;
  assign samples[1] = s1_pix.green_in;
  assign samples[2] = s1_pix.blue_in;

  for (genvar c = 0; c < NC; c++) begin : g_lane
    assign stored[c] = s1_first ? '0 : $signed(stored_raw[c*EB +: EB]);
    assign left_word[c*EB +: EB] = sum_left[c];
    assign mid_word[c*EB +: EB] = sum_mid[c];

    fsd_lane #(.EB(EB)) u_lane (
      .sample(samples[c]),
      .carry(right_carry[c]),
      .stored(stored[c]),
      .pend_left(pend_left[c]),
      .pend_mid(pend_mid[c]),
      .on(on[c]),
      .share_right(share_right[c]),
      .sum_left(sum_left[c]),
      .sum_mid(sum_mid[c]),
      .share_lr(share_lr[c])
    );
  end

  // merge: carries, pending sums and line-store writes
  logic          s1_wr_left, s1_wr_mid, tail_set;
  logic          tail_valid;
  logic [AW-1:0] tail_addr;
  logic [MW-1:0] tail_data;

  assign s1_wr_left = s1_valid && s1_below && (s1_col != '0);
  assign s1_wr_mid = s1_valid && s1_below && s1_eor && (s1_col == '0);
  // row end with two columns due: the last one goes out next cycle,
  // when the new row's first pixel has nothing to write
  assign tail_set = s1_valid && s1_below && s1_eor && (s1_col != '0);

  always_comb begin
    wr_en = tail_valid || s1_wr_left || s1_wr_mid;
    if (tail_valid) begin
      wr_addr = tail_addr;
      wr_data = tail_data;
    end else if (s1_wr_left) begin
      wr_addr = s1_col - 1'b1;
      wr_data = left_word;
    end else begin
      wr_addr = s1_col;
      wr_data = mid_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tail_valid <= 1'b0;
      for (int c = 0; c < NC; c++) begin
        right_carry[c] <= '0;
        pend_left[c] <= '0;
        pend_mid[c] <= '0;
      end
    end else begin
      tail_valid <= tail_set;
      if (s1_valid) begin
        for (int c = 0; c < NC; c++) begin
          right_carry[c] <= s1_eor ? '0 : share_right[c];
          if (s1_below && !s1_eor) begin
            pend_left[c] <= sum_mid[c];
            pend_mid[c] <= share_lr[c];
          end else begin
            pend_left[c] <= '0;
            pend_mid[c] <= '0;
          end
        end
      end
    end
    if (tail_set) begin
      tail_addr <= s1_col;
      tail_data <= mid_word;
    end
  end

  // output FIFO
  fsd_pkg::dith_t                 result;
  logic [fsd_pkg::OUT_CNT_W-1:0]  fifo_count;
  logic [fsd_pkg::OUT_CNT_W-1:0]  in_flight;

  assign result.red_on = on[0];
  assign result.green_on = on[1];
  assign result.blue_on = on[2];
  assign result.end_of_row = s1_eor;
  assign result.end_of_image = s1_eoi;

  fsd_out_fifo u_fifo (
    .clk(clk),
    .rst(rst),
    .push(s1_valid),
    .push_data(result),
    .pop(dith_valid && !dith_stall),
    .head(dith),
    .count(fifo_count)
  );

  assign dith_valid = (fifo_count != '0);
  assign in_flight = fifo_count + {{(fsd_pkg::OUT_CNT_W-1){1'b0}}, s1_valid};
  assign pix_stall = (in_flight >= fsd_pkg::OUT_CNT_W'(fsd_pkg::OUT_FIFO_DEPTH));

`ifndef SYNTHESIS
  a_stage1_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted pixel did not reach stage 1");

  a_carry_cleared: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_eor) |=> (right_carry[0] == '0 && right_carry[1] == '0
                              && right_carry[2] == '0))
    else $error("right carry not cleared at row end");

  a_tail_origin: assert property (@(posedge clk) disable iff (rst)
    tail_valid |-> $past(s1_valid && s1_eor && s1_below))
    else $error("deferred line write without a row end");

  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    in_flight <= fsd_pkg::OUT_CNT_W'(fsd_pkg::OUT_FIFO_DEPTH))
    else $error("more results in flight than the output FIFO holds");
`endif

endmodule

// ----- verif/floyd_steinberg_dither_rgb_tb.sv -----
// Self-checking testbench for floyd_steinberg_dither_rgb: directed and random RGB pixel
// streams over many line/frame geometries, checked against an in-bench error-diffusion predictor.
// Depends on fsd_pkg and the floyd_steinberg_dither_rgb design files.
`timescale 1ns / 1ps

module testbench;

  localparam int LINE_MAX      = 2048;
  localparam int ERR_HI        = 511;   // signed 10-bit error store
  localparam int ERR_LO        = -512;
  localparam int RANDOM_PIXELS = 1200;
  localparam logic [fsd_pkg::CFG_INDEX_W-1:0] SPARE_INDEX_LO = 2'd2;
  localparam logic [fsd_pkg::CFG_INDEX_W-1:0] SPARE_INDEX_HI = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pix_valid = 1'b0;
  logic pix_stall;
  fsd_pkg::pix_t pix = '0;
  logic dith_valid;
  logic dith_stall = 1'b0;
  fsd_pkg::dith_t dith;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [fsd_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [fsd_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  bit calm = 1'b0;  // no idling on either side while set

  floyd_steinberg_dither_rgb dut (
    .clk        (clk),
    .rst        (rst),
    .pix_valid  (pix_valid),
    .pix_stall  (pix_stall),
    .pix        (pix),
    .dith_valid (dith_valid),
    .dith_stall (dith_stall),
    .dith       (dith),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  class dither_checker;
    int row_below_err[LINE_MAX][3];
    int carry_right[3];
    int below_part[2][3];  // [0]: lower-left of next pixel, [1]: lower of next pixel
    int col;
    int row;
    int line_width;
    int frame_height;
    fsd_pkg::dith_t expected_dots[$];
    int errors;
    int checked;

    function new();
      line_width   = fsd_pkg::LINE_WIDTH_RESET;
      frame_height = fsd_pkg::FRAME_HEIGHT_RESET;
    endfunction

    function int clip_err(int v);
      if (v > ERR_HI) return ERR_HI;
      if (v < ERR_LO) return ERR_LO;
      return v;
    endfunction

    function int share(int e, int num);
      return clip_err((e * num) / 16);  // truncates toward zero
    endfunction

    function int width_now(int raw);
      if (raw < 1) return 1;
      if (raw > LINE_MAX) return LINE_MAX;
      return raw;
    endfunction

    function int height_now(int raw);
      if (raw < 1) return 1;
      if (raw > fsd_pkg::MAX_FRAME_HEIGHT) return fsd_pkg::MAX_FRAME_HEIGHT;
      return raw;
    endfunction

    function bit at_frame_start();
      return col == 0 && row == 0;
    endfunction

    function void set_reg(logic [fsd_pkg::CFG_INDEX_W-1:0] idx,
                          logic [fsd_pkg::CFG_DATA_W-1:0] data);
      if (idx == fsd_pkg::REG_LINE_WIDTH) line_width = int'(data[11:0]);
      else if (idx == fsd_pkg::REG_FRAME_HEIGHT) frame_height = int'(data);
    endfunction

    function void take_pixel(fsd_pkg::pix_t p);
      int w, h, x, y, v, e, p0, stored;
      int samp[3];
      bit on[3];
      bit eor, eoi, below;
      fsd_pkg::dith_t r;
      w = width_now(line_width);
      h = frame_height;
      if (h < 1) h = 1;
      if (h > fsd_pkg::MAX_FRAME_HEIGHT) h = fsd_pkg::MAX_FRAME_HEIGHT;
      x = col;
      y = row;
      if (x >= LINE_MAX) x = LINE_MAX - 1;
      eor = (x + 1 >= w);
      eoi = eor && (y + 1 >= h);
      below = (y + 1 < h);
      samp[0] = int'(p.red_in);
      samp[1] = int'(p.green_in);
      samp[2] = int'(p.blue_in);
      for (int c = 0; c < 3; c++) begin
        stored = (y == 0) ? 0 : row_below_err[x][c];
        v = samp[c] + carry_right[c] + stored;
        on[c] = (v >= fsd_pkg::ON_THRESHOLD);
        e = clip_err(v - (on[c] ? fsd_pkg::FULL_SCALE : 0));
        carry_right[c] = eor ? 0 : share(e, fsd_pkg::SHARE_RIGHT);
        if (below) begin
          if (x > 0)
            row_below_err[x-1][c] = clip_err(below_part[0][c] +
                                             share(e, fsd_pkg::SHARE_BELOW_LEFT));
          p0 = clip_err(below_part[1][c] + share(e, fsd_pkg::SHARE_BELOW));
          if (eor) begin
            row_below_err[x][c] = p0;
            below_part[0][c] = 0;
            below_part[1][c] = 0;
          end else begin
            below_part[0][c] = p0;
            below_part[1][c] = share(e, fsd_pkg::SHARE_BELOW_RIGHT);
          end
        end else begin
          below_part[0][c] = 0;
          below_part[1][c] = 0;
        end
      end
      r.red_on       = on[0];
      r.green_on     = on[1];
      r.blue_on      = on[2];
      r.end_of_row   = eor;
      r.end_of_image = eoi;
      expected_dots.push_back(r);
      if (eor) begin
        col = 0;
        row = eoi ? 0 : y + 1;
      end else begin
        col = x + 1;
      end
    endfunction

    task flag_error(string msg);
      errors++;
      if (errors <= 20) $display("ERROR %0t: %s", $time, msg);
    endtask

    task check_dot(fsd_pkg::dith_t got);
      fsd_pkg::dith_t want;
      string names[5];
      names = '{"red_on", "green_on", "blue_on", "end_of_row", "end_of_image"};
      if (expected_dots.size() == 0) begin
        flag_error($sformatf("result %b with no pixel outstanding", got));
        return;
      end
      want = expected_dots.pop_front();
      checked++;
      for (int i = 0; i < 5; i++)
        if (got[4-i] !== want[4-i])
          flag_error($sformatf("pixel %0d %s = %b, expected %b",
                               checked, names[i], got[4-i], want[4-i]));
    endtask
  endclass

  dither_checker book = new();

  always #6 clk = ~clk;

  always @(negedge clk) begin
    dith_stall <= !calm && ($urandom_range(99) < 19);
  end

  always @(posedge clk) begin
    if (!rst && dith_valid && !dith_stall) book.check_dot(dith);
  end

  function automatic fsd_pkg::pix_t rgb(int r, int g, int b);
    fsd_pkg::pix_t p;
    p.red_in   = r[7:0];
    p.green_in = g[7:0];
    p.blue_in  = b[7:0];
    return p;
  endfunction

  int tone = 128;

  // mix of flat-ish image areas, threshold corners and uniform noise
  function automatic fsd_pkg::pix_t random_pixel();
    int corner[4];
    corner = '{0, 127, 128, 255};
    case ($urandom_range(9))
      0, 1: return rgb(corner[$urandom_range(3)], corner[$urandom_range(3)],
                       corner[$urandom_range(3)]);
      2, 3, 4: begin
        tone = tone + $urandom_range(8) - 4;
        if (tone < 4) tone = 4;
        if (tone > 251) tone = 251;
        return rgb(tone + $urandom_range(6) - 3, tone + $urandom_range(6) - 3,
                   tone + $urandom_range(6) - 3);
      end
      default: return rgb($urandom_range(255), $urandom_range(255), $urandom_range(255));
    endcase
  endfunction

  task automatic send_pixel(fsd_pkg::pix_t p);
    while (!calm && $urandom_range(99) < 19) begin
      pix_valid = 1'b0;
      @(negedge clk);
    end
    pix_valid = 1'b1;
    pix = p;
    do @(posedge clk); while (pix_stall);
    book.take_pixel(p);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    pix_valid = 1'b0;
    while (book.expected_dots.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [fsd_pkg::CFG_INDEX_W-1:0] idx,
                           logic [fsd_pkg::CFG_DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    book.set_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // mid-frame the row may only get narrower and a last row stays last,
  // so the line store is never read unwritten
  task automatic set_geometry(int w, int h);
    if (!book.at_frame_start() && book.width_now(w) > book.width_now(book.line_width))
      w = book.line_width;
    if (!book.at_frame_start() && book.row + 1 >= book.height_now(book.frame_height)
        && book.row + 1 < book.height_now(h))
      h = book.frame_height;
    write_reg(fsd_pkg::REG_LINE_WIDTH, {1'($urandom_range(1)), w[11:0]});
    write_reg(fsd_pkg::REG_FRAME_HEIGHT, h[12:0]);
  endtask

  initial begin
    #6_000_000;
    $display("timeout with %0d results outstanding", book.expected_dots.size());
    $display("floyd_steinberg_dither_rgb: mismatch");
    $finish;
  end

  initial begin
    int sent, n, w, h;
    int wide_w[5];
    int tall_h[5];
    wide_w = '{0, 1, 2048, 2049, 4095};
    tall_h = '{0, 1, 4096, 4097, 8191};
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // reset geometry, channel extremes around the threshold
    send_pixel(rgb(0, 0, 0));
    send_pixel(rgb(255, 255, 255));
    send_pixel(rgb(128, 127, 128));
    send_pixel(rgb(127, 128, 1));
    wait_drained();

    // unknown indexes are dropped; zero sizes act as one, column already past the width
    write_reg(SPARE_INDEX_LO, 13'($urandom));
    write_reg(SPARE_INDEX_HI, 13'($urandom));
    set_geometry(0, 0);
    send_pixel(rgb(200, 60, 128));
    send_pixel(rgb(127, 255, 0));
    send_pixel(rgb(128, 128, 128));
    wait_drained();

    // one whole 3x2 frame: first row, last row, both edges
    set_geometry(3, 2);
    send_pixel(rgb(100, 200, 50));
    send_pixel(rgb(127, 128, 255));
    send_pixel(rgb(255, 0, 127));
    send_pixel(rgb(200, 100, 30));
    send_pixel(rgb(64, 192, 128));
    send_pixel(rgb(0, 255, 129));
    wait_drained();

    // height cut mid-frame to below the current row, which stays the last one
    set_geometry(2, 3);
    repeat (2) send_pixel(rgb(90, 170, 140));
    repeat (2) send_pixel(rgb(160, 80, 120));
    wait_drained();
    set_geometry(2, 1);
    send_pixel(rgb(140, 120, 60));
    send_pixel(rgb(30, 240, 200));
    wait_drained();

    // oversized registers clamp to the largest geometry
    set_geometry(4095, 8191);

    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      case ($urandom_range(11))
        0: begin
          w = wide_w[$urandom_range(4)];
          h = $urandom_range(1, 8);
        end
        1: begin
          w = $urandom_range(1, 16);
          h = tall_h[$urandom_range(4)];
        end
        default: begin
          w = $urandom_range(1, 24);
          h = $urandom_range(1, 6);
        end
      endcase
      n = $urandom_range(12, 90);
      wait_drained();
      calm = (sent >= 500 && sent < 800);
      if ($urandom_range(7) == 0) write_reg(SPARE_INDEX_HI, 13'($urandom));
      set_geometry(w, h);
      repeat (n) begin
        send_pixel(random_pixel());
        sent++;
      end
    end

    wait_drained();
    repeat (8) @(negedge clk);
    if (book.errors == 0)
      $display("floyd_steinberg_dither_rgb: match");
    else
      $display("floyd_steinberg_dither_rgb: mismatch");
    $finish;
  end

endmodule

// ----- sim.f -----
design/fsd_pkg.sv
design/fsd_ram.sv
design/fsd_lane.sv
design/fsd_out_fifo.sv
design/floyd_steinberg_dither_rgb.sv
verif/floyd_steinberg_dither_rgb_tb.sv
